FILE: hw/rtl/btic_pkg.sv
// Package for the bilinear table interpolation core: request codes,
// register indexes, field widths and shared types. No dependencies.
package btic_pkg;

  // Transaction request codes
  typedef enum logic [1:0] {
    REQ_LOOKUP   = 2'd0,
    REQ_WR_SPEED = 2'd1,
    REQ_WR_PRESS = 2'd2,
    REQ_WR_CELL  = 2'd3
  } req_type_e;

  // Register index (byte address bit 2)
  localparam logic REG_SPEED_SCALE  = 1'b0;
  localparam logic REG_OUTPUT_SCALE = 1'b1;

  // Field widths
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned WT_W     = 7;
  localparam int unsigned SCALE_W  = 8;
  localparam int unsigned OSCALE_W = 10;

  // Arithmetic widths
  localparam int unsigned NUM_W  = 23;  // (v - lo) * 100
  localparam int unsigned WQ_W   = 10;  // quotient bits of weight and divisor dividers
  localparam int unsigned BW_W   = 14;  // blend weight, up to 100 * 100
  localparam int unsigned SUM_W  = 22;  // weighted sum, up to 255 * 10000

  // Constants
  localparam int unsigned PCT_FULL    = 100;
  localparam int unsigned SUM_DIVIDEND = 1000;

  // Four corner cells of a lookup
  typedef struct packed {
    logic [DATA_W-1:0] c_ll;  // low pressure, low speed
    logic [DATA_W-1:0] c_lh;  // low pressure, high speed
    logic [DATA_W-1:0] c_hl;  // high pressure, low speed
    logic [DATA_W-1:0] c_hh;  // high pressure, high speed
  } cells_t;

  // Sideband carried through the final divider
  typedef struct packed {
    logic            lookup;
    logic [WT_W-1:0] sw;
    logic [WT_W-1:0] pw;
  } tail_side_t;

endpackage

FILE: hw/rtl/bilinear_table_interpolation_core.sv
// Top level of the bilinear table interpolation core: engine map store,
// bracket search, weight and blend pipeline, register port.
// Depends on btic_pkg, btic_axis, btic_ram, btic_div.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | input     | in_valid_i / in_stall_o    | req_type, speed, pressure, indexes, data
//  out     | output    | out_valid_o / out_stall_i  | interpolated_value, weights
//  apb     | input     | psel/penable/pwrite/pready | speed_bin_scale, output_scale
//
// Every transaction yields one result, computed through the two pipelined
// dividers. One transaction may enter per cycle while in_stall_o is low.
// Reset clears valid bits and sets the registers to their defaults (speed
// scale 100, output scale 1); the map contents are undefined until written.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module bilinear_table_interpolation_core import btic_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic [VAL_W-1:0]     engine_speed_i,
  input  logic [VAL_W-1:0]     manifold_pressure_i,
  input  logic [IDX_W-1:0]     row_index_i,
  input  logic [IDX_W-1:0]     column_index_i,
  input  logic [DATA_W-1:0]    write_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VAL_W-1:0]     interpolated_value_o,
  output logic [WT_W-1:0]      speed_weight_o,
  output logic [WT_W-1:0]      pressure_weight_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned AW = $clog2(TABLE_SIZE * TABLE_SIZE);

  logic en;
  logic accept;

  // Registers
  logic [SCALE_W-1:0]  speed_scale_q;
  logic [OSCALE_W-1:0] out_scale_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_scale_q <= SCALE_W'(100);
      out_scale_q   <= OSCALE_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SPEED_SCALE) begin
        speed_scale_q <= pwdata[SCALE_W-1:0];
      end else begin
        out_scale_q <= pwdata[OSCALE_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_OUTPUT_SCALE) ? 32'(out_scale_q) : 32'(speed_scale_q);

  // Global advance: hold everything while a result waits
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  // Stage 1: capture transaction
  logic               v1_q;
  logic [1:0]         type1_q;
  logic [VAL_W-1:0]   spd1_q, prs1_q;
  logic [IDX_W-1:0]   row1_q, col1_q;
  logic [DATA_W-1:0]  data1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type1_q <= req_type_i;
      spd1_q  <= engine_speed_i;
      prs1_q  <= manifold_pressure_i;
      row1_q  <= row_index_i;
      col1_q  <= column_index_i;
      data1_q <= write_data_i;
    end
  end

  // Breakpoint stores and bracket search (writes taken at acceptance)
  logic [IW-1:0]    slo, shi, plo, phi;
  logic [VAL_W-1:0] stlo, sthi, ptlo, pthi;

  btic_axis #(.TABLE_SIZE(TABLE_SIZE)) u_speed_axis (
    .clk_i     (clk_i),
    .wr_en_i   (accept && (req_type_i == REQ_WR_SPEED)),
    .wr_idx_i  (row_index_i),
    .wr_data_i (write_data_i),
    .mul_i     (speed_scale_q),
    .value_i   (spd1_q),
    .lo_idx_o  (slo),
    .hi_idx_o  (shi),
    .lo_val_o  (stlo),
    .hi_val_o  (sthi)
  );

  btic_axis #(.TABLE_SIZE(TABLE_SIZE)) u_press_axis (
    .clk_i     (clk_i),
    .wr_en_i   (accept && (req_type_i == REQ_WR_PRESS)),
    .wr_idx_i  (row_index_i),
    .wr_data_i (write_data_i),
    .mul_i     (SCALE_W'(1)),
    .value_i   (prs1_q),
    .lo_idx_o  (plo),
    .hi_idx_o  (phi),
    .lo_val_o  (ptlo),
    .hi_val_o  (pthi)
  );

  // Stage 2: bracket results, cell write
  logic               v2_q, lookup2_q, cwr2_q;
  logic [AW-1:0]      cwaddr2_q;
  logic [DATA_W-1:0]  cdata2_q;
  logic [VAL_W-1:0]   spd2_q, prs2_q, stlo2_q, sthi2_q, ptlo2_q, pthi2_q;
  logic [IW-1:0]      slo2_q, shi2_q, plo2_q, phi2_q;
  logic               cell_ok;

  assign cell_ok = (32'(row1_q) < TABLE_SIZE) && (32'(col1_q) < TABLE_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lookup2_q <= type1_q == REQ_LOOKUP;
      cwr2_q    <= (type1_q == REQ_WR_CELL) && cell_ok;
      cwaddr2_q <= AW'(AW'(row1_q) * AW'(TABLE_SIZE)) + AW'(col1_q);
      cdata2_q  <= data1_q;
      spd2_q    <= spd1_q;
      prs2_q    <= prs1_q;
      stlo2_q   <= stlo;
      sthi2_q   <= sthi;
      ptlo2_q   <= ptlo;
      pthi2_q   <= pthi;
      slo2_q    <= slo;
      shi2_q    <= shi;
      plo2_q    <= plo;
      phi2_q    <= phi;
    end
  end

  // Corner cell reads, one RAM copy per corner
  logic [AW-1:0] ra_ll, ra_lh, ra_hl, ra_hh;
  cells_t        cells3;

  assign ra_ll = AW'(AW'(plo2_q) * AW'(TABLE_SIZE)) + AW'(slo2_q);
  assign ra_lh = AW'(AW'(plo2_q) * AW'(TABLE_SIZE)) + AW'(shi2_q);
  assign ra_hl = AW'(AW'(phi2_q) * AW'(TABLE_SIZE)) + AW'(slo2_q);
  assign ra_hh = AW'(AW'(phi2_q) * AW'(TABLE_SIZE)) + AW'(shi2_q);

  btic_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SIZE * TABLE_SIZE)) u_ram_ll (
    .clk_i (clk_i), .we_i (en && v2_q && cwr2_q), .waddr_i (cwaddr2_q),
    .wdata_i (cdata2_q), .re_i (en), .raddr_i (ra_ll), .rdata_o (cells3.c_ll)
  );
  btic_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SIZE * TABLE_SIZE)) u_ram_lh (
    .clk_i (clk_i), .we_i (en && v2_q && cwr2_q), .waddr_i (cwaddr2_q),
    .wdata_i (cdata2_q), .re_i (en), .raddr_i (ra_lh), .rdata_o (cells3.c_lh)
  );
  btic_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SIZE * TABLE_SIZE)) u_ram_hl (
    .clk_i (clk_i), .we_i (en && v2_q && cwr2_q), .waddr_i (cwaddr2_q),
    .wdata_i (cdata2_q), .re_i (en), .raddr_i (ra_hl), .rdata_o (cells3.c_hl)
  );
  btic_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SIZE * TABLE_SIZE)) u_ram_hh (
    .clk_i (clk_i), .we_i (en && v2_q && cwr2_q), .waddr_i (cwaddr2_q),
    .wdata_i (cdata2_q), .re_i (en), .raddr_i (ra_hh), .rdata_o (cells3.c_hh)
  );

  // Percent numerators and denominators, edge cases folded in
  logic [NUM_W-1:0] snum, pnum;
  logic [VAL_W-1:0] sden, pden;
  logic [VAL_W-1:0] sdiff, pdiff;

  assign sdiff = spd2_q - stlo2_q;
  assign pdiff = prs2_q - ptlo2_q;

  always_comb begin
    if (spd2_q <= stlo2_q) begin
      snum = '0;
      sden = VAL_W'(1);
    end else if (spd2_q >= sthi2_q) begin
      snum = NUM_W'(PCT_FULL);
      sden = VAL_W'(1);
    end else begin
      snum = NUM_W'(sdiff) * NUM_W'(PCT_FULL);
      sden = sthi2_q - stlo2_q;
    end
  end

  always_comb begin
    if (prs2_q <= ptlo2_q) begin
      pnum = '0;
      pden = VAL_W'(1);
    end else if (prs2_q >= pthi2_q) begin
      pnum = NUM_W'(PCT_FULL);
      pden = VAL_W'(1);
    end else begin
      pnum = NUM_W'(pdiff) * NUM_W'(PCT_FULL);
      pden = pthi2_q - ptlo2_q;
    end
  end

  // Stage 3: divider operands
  logic                v3_q, lookup3_q;
  logic [NUM_W-1:0]    snum3_q, pnum3_q;
  logic [VAL_W-1:0]    sden3_q, pden3_q;
  logic [OSCALE_W-1:0] oden3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lookup3_q <= lookup2_q;
      snum3_q   <= snum;
      pnum3_q   <= pnum;
      sden3_q   <= sden;
      pden3_q   <= pden;
      oden3_q   <= (out_scale_q == '0) ? OSCALE_W'(1) : out_scale_q;
    end
  end

  // Weight and divisor dividers, running side by side
  logic             vd_s, vd_p, vd_o;
  logic [WQ_W-1:0]  sq, pq, oq;
  cells_t           cells_d;
  logic             look_p, look_o;

  btic_div #(.NW(NUM_W), .DW(VAL_W), .QW(WQ_W), .SW($bits(cells_t))) u_div_speed (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v3_q),
    .num_i (snum3_q), .den_i (sden3_q), .side_i (cells3),
    .valid_o (vd_s), .quo_o (sq), .side_o (cells_d)
  );

  btic_div #(.NW(NUM_W), .DW(VAL_W), .QW(WQ_W), .SW(1)) u_div_press (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v3_q),
    .num_i (pnum3_q), .den_i (pden3_q), .side_i (lookup3_q),
    .valid_o (vd_p), .quo_o (pq), .side_o (look_p)
  );

  btic_div #(.NW(OSCALE_W), .DW(OSCALE_W), .QW(WQ_W), .SW(1)) u_div_scale (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v3_q),
    .num_i (OSCALE_W'(SUM_DIVIDEND)), .den_i (oden3_q), .side_i (lookup3_q),
    .valid_o (vd_o), .quo_o (oq), .side_o (look_o)
  );

  logic [WT_W-1:0] sw_d, pw_d, nsw_d, npw_d;

  assign sw_d  = sq[WT_W-1:0];
  assign pw_d  = pq[WT_W-1:0];
  assign nsw_d = WT_W'(PCT_FULL) - sw_d;
  assign npw_d = WT_W'(PCT_FULL) - pw_d;

  // Stage W: blend weights
  logic               vw_q, lookw_q;
  logic [WT_W-1:0]    sww_q, pww_q;
  logic [WQ_W-1:0]    divw_q;
  cells_t             cellsw_q;
  logic [BW_W-1:0]    w_ll_q, w_lh_q, w_hl_q, w_hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q <= 1'b0;
    end else if (en) begin
      vw_q <= vd_s && vd_p && vd_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lookw_q  <= look_p && look_o;
      sww_q    <= sw_d;
      pww_q    <= pw_d;
      divw_q   <= (oq == '0) ? WQ_W'(1) : oq;
      cellsw_q <= cells_d;
      w_ll_q   <= BW_W'(npw_d) * BW_W'(nsw_d);
      w_lh_q   <= BW_W'(npw_d) * BW_W'(sw_d);
      w_hl_q   <= BW_W'(pw_d) * BW_W'(nsw_d);
      w_hh_q   <= BW_W'(pw_d) * BW_W'(sw_d);
    end
  end

  // Stage P: cell products
  logic               vp_q, lookp_q;
  logic [WT_W-1:0]    swp_q, pwp_q;
  logic [WQ_W-1:0]    divp_q;
  logic [SUM_W-1:0]   p_ll_q, p_lh_q, p_hl_q, p_hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= vw_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lookp_q <= lookw_q;
      swp_q   <= sww_q;
      pwp_q   <= pww_q;
      divp_q  <= divw_q;
      p_ll_q  <= SUM_W'(cellsw_q.c_ll) * SUM_W'(w_ll_q);
      p_lh_q  <= SUM_W'(cellsw_q.c_lh) * SUM_W'(w_lh_q);
      p_hl_q  <= SUM_W'(cellsw_q.c_hl) * SUM_W'(w_hl_q);
      p_hh_q  <= SUM_W'(cellsw_q.c_hh) * SUM_W'(w_hh_q);
    end
  end

  // Stage S: weighted sum
  logic             vs_q;
  tail_side_t       sides_q;
  logic [WQ_W-1:0]  divs_q;
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W+1:0] sum_wide;

  assign sum_wide = (SUM_W+2)'(p_ll_q) + (SUM_W+2)'(p_lh_q)
                  + (SUM_W+2)'(p_hl_q) + (SUM_W+2)'(p_hh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (en) begin
      vs_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sides_q.lookup <= lookp_q;
      sides_q.sw     <= swp_q;
      sides_q.pw     <= pwp_q;
      divs_q         <= divp_q;
      sum_q          <= sum_wide[SUM_W-1:0];
    end
  end

  // Final division of the sum
  logic             vf;
  logic [SUM_W-1:0] fq;
  tail_side_t       sidef;

  btic_div #(.NW(SUM_W), .DW(WQ_W), .QW(SUM_W), .SW($bits(tail_side_t))) u_div_sum (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (vs_q),
    .num_i (sum_q), .den_i (divs_q), .side_i (sides_q),
    .valid_o (vf), .quo_o (fq), .side_o (sidef)
  );

  // Output register; write transactions report zeros
  logic             out_valid_q;
  logic [VAL_W-1:0] value_q;
  logic [WT_W-1:0]  sw_q, pw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q <= sidef.lookup ? fq[VAL_W-1:0] : '0;
      sw_q    <= sidef.lookup ? sidef.sw : '0;
      pw_q    <= sidef.lookup ? sidef.pw : '0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign interpolated_value_o = value_q;
  assign speed_weight_o       = sw_q;
  assign pressure_weight_o    = pw_q;

endmodule

FILE: hw/rtl/btic_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module btic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/btic_axis.sv
// One axis of the map: breakpoint store and bracket search.
// Depends on btic_pkg.
module btic_axis import btic_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [IDX_W-1:0]              wr_idx_i,
  input  logic [DATA_W-1:0]             wr_data_i,
  input  logic [SCALE_W-1:0]            mul_i,
  input  logic [VAL_W-1:0]              value_i,
  output logic [$clog2(TABLE_SIZE)-1:0] lo_idx_o,
  output logic [$clog2(TABLE_SIZE)-1:0] hi_idx_o,
  output logic [VAL_W-1:0]              lo_val_o,
  output logic [VAL_W-1:0]              hi_val_o
);

  localparam int unsigned IW = $clog2(TABLE_SIZE);

  logic [DATA_W-1:0]     bp_q [TABLE_SIZE];
  logic [VAL_W-1:0]      thr  [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] gt;
  logic [IW-1:0]         first;
  logic                  found;
  logic                  in_range;

  assign in_range = 32'(wr_idx_i) < TABLE_SIZE;

  // Breakpoint writes, out-of-range indexes dropped
  always_ff @(posedge clk_i) begin
    if (wr_en_i && in_range) begin
      bp_q[IW'(wr_idx_i)] <= wr_data_i;
    end
  end

  // Scaled thresholds and compares, one lane per breakpoint
  always_comb begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      thr[i] = {8'h00, bp_q[i]} * {8'h00, mul_i};
      gt[i]  = value_i > thr[i];
    end
  end

  // First breakpoint not below the input
  always_comb begin
    first = '0;
    found = 1'b0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (!gt[i]) begin
        first = IW'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    if (!found) begin
      lo_idx_o = IW'(TABLE_SIZE - 1);
      hi_idx_o = IW'(TABLE_SIZE - 1);
    end else if (value_i == thr[first]) begin
      lo_idx_o = first;
      hi_idx_o = first;
    end else begin
      hi_idx_o = first;
      lo_idx_o = (first == '0) ? '0 : first - IW'(1);
    end
  end

  assign lo_val_o = thr[lo_idx_o];
  assign hi_val_o = thr[hi_idx_o];

endmodule

FILE: hw/rtl/btic_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Requires num < den * 2**QW. Depends on nothing.
module btic_div #(
  parameter int unsigned NW = 22,
  parameter int unsigned DW = 10,
  parameter int unsigned QW = 22,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned CW = NW + DW + QW;

  logic [NW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic [QW-1:0] vld_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [CW-1:0] cand;
    logic [CW-1:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Trial subtract of the shifted divisor
    assign cand = CW'(den_in) << (QW - 1 - k);
    assign diff = CW'(rem_in) - cand;
    assign ge   = CW'(rem_in) >= cand;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? NW'(diff) : rem_in;
        den_q[k]  <= den_in;
        quo_q[k]  <= quo_in | (QW'(ge) << (QW - 1 - k));
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule
